// ===== src/sacache_pkg.sv =====
// ----------------------------------------------------------------------------
// sacache_pkg
// Shared constants, types and helpers for the set-associative cache with
// MRU-bit pseudo-LRU replacement.
// ----------------------------------------------------------------------------
package sacache_pkg;

   localparam int MAX_SETS       = 256;
   localparam int MAX_WAYS       = 8;

   localparam int ADDR_W         = 32;
   localparam int TAG_W          = 32;
   localparam int CNT_W          = 32;
   localparam int CFG_W          = 4;
   localparam int CSR_IDX_W      = 2;
   localparam int OUT_WAY_W      = 3;

   localparam int SET_W          = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W          = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SETS_LOG2_MAX  = $clog2(MAX_SETS);

   localparam logic [CFG_W-1:0] BLOCK_LOG2_RST = CFG_W'(4);
   localparam logic [CFG_W-1:0] SETS_LOG2_RST  = CFG_W'(4);
   localparam logic [CFG_W-1:0] WAYS_RST       = CFG_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_BYTES_LOG2 = 2'd0,
      CSR_SETS_LOG2        = 2'd1,
      CSR_WAYS_IN_USE      = 2'd2
   } csr_idx_type;

   // one memory row holds a whole set
   typedef struct packed {
      logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
      logic [MAX_WAYS-1:0]            vld;
      logic [MAX_WAYS-1:0]            mru;
   } row_type;

   // index of the lowest set bit, zero when none
   function automatic logic [WAY_W-1:0] lowest_one(input logic [MAX_WAYS-1:0] vec);
      logic [WAY_W-1:0] idx;
      idx = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = WAY_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== src/set_assoc_cache_mru_bit_plru.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_mru_bit_plru
// Set-associative cache tag store with MRU-bit pseudo-LRU replacement and
// running hit and miss counters.
// ----------------------------------------------------------------------------
// Takes one address per cycle unless req_stall is raised. On acceptance the set
// row (all ways' tags, valid and MRU bits) is read from a single-port-read,
// single-port-write memory into a register; from there the ways are compared
// in parallel, the victim is chosen, and the updated row is written back while
// the result is loaded into the output register. A row written in the same
// cycle that a following transaction reads it is forwarded, so back-to-back
// accesses to one set see the fresh row. A per-row valid flag, cleared by
// reset, makes all lines read invalid after reset with no clearing pass.
// Configuration may only be changed while idle.
module set_assoc_cache_mru_bit_plru (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sacache_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sacache_pkg::CFG_W-1:0]       csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sacache_pkg::ADDR_W-1:0]      req_phys_addr,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [sacache_pkg::OUT_WAY_W-1:0]   rsp_way_used,
   output logic [sacache_pkg::CNT_W-1:0]       rsp_hit_total,
   output logic [sacache_pkg::CNT_W-1:0]       rsp_miss_total
);

   localparam int MAX_WAYS = sacache_pkg::MAX_WAYS;
   localparam int MAX_SETS = sacache_pkg::MAX_SETS;
   localparam int SET_W    = sacache_pkg::SET_W;
   localparam int WAY_W    = sacache_pkg::WAY_W;
   localparam int CFG_W    = sacache_pkg::CFG_W;
   localparam int TAG_W    = sacache_pkg::TAG_W;
   localparam int ADDR_W   = sacache_pkg::ADDR_W;
   localparam int CNT_W    = sacache_pkg::CNT_W;

   // configuration
   logic [CFG_W-1:0] blk_log2_ff, blk_log2_in;
   logic [CFG_W-1:0] sets_log2_ff, sets_log2_in;
   logic [CFG_W-1:0] ways_ff, ways_in;

   // set memory and row valid flags
   sacache_pkg::row_type mem [MAX_SETS];
   logic [MAX_SETS-1:0]  row_vld_ff, row_vld_in;

   // lookup stage
   logic                 s1_vld_ff, s1_vld_in;
   logic [SET_W-1:0]     s1_set_ff;
   logic [TAG_W-1:0]     s1_tag_ff;
   sacache_pkg::row_type rd_row_ff;
   logic                 rd_rowvld_ff;
   logic                 fwd_ff, fwd_in;
   sacache_pkg::row_type fwd_row_ff;

   // output register and counters
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [WAY_W-1:0]      rsp_way_ff;
   logic [CNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]      miss_cnt_ff, miss_cnt_in;

   logic                  accept;
   logic                  adv;
   logic [CFG_W-1:0]      sets_eff;
   logic [CFG_W-1:0]      ways_eff;
   logic [ADDR_W-1:0]     blk;
   logic [SET_W-1:0]      set_idx;
   logic [TAG_W-1:0]      tag;

   sacache_pkg::row_type  row_cur;
   sacache_pkg::row_type  row_new;
   logic [MAX_WAYS-1:0]   in_use;
   logic [MAX_WAYS-1:0]   hit_vec;
   logic [MAX_WAYS-1:0]   inv_vec;
   logic [MAX_WAYS-1:0]   free_vec;
   logic [MAX_WAYS-1:0]   way_oh;
   logic [MAX_WAYS-1:0]   mru_set;
   logic [MAX_WAYS-1:0]   mru_clr;
   logic                  hit;
   logic [WAY_W-1:0]      way_sel;

   // handshake
   assign adv       = s1_vld_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // configuration writes
   always_comb begin
      blk_log2_in  = blk_log2_ff;
      sets_log2_in = sets_log2_ff;
      ways_in      = ways_ff;
      if (csr_wr_en) begin
         case (sacache_pkg::csr_idx_type'(csr_index))
            sacache_pkg::CSR_BLOCK_BYTES_LOG2: blk_log2_in  = csr_wdata;
            sacache_pkg::CSR_SETS_LOG2:        sets_log2_in = csr_wdata;
            sacache_pkg::CSR_WAYS_IN_USE:      ways_in      = csr_wdata;
            default: ;
         endcase
      end
   end

   // address split
   always_comb begin
      sets_eff = (int'(sets_log2_ff) > sacache_pkg::SETS_LOG2_MAX) ?
                 CFG_W'(sacache_pkg::SETS_LOG2_MAX) : sets_log2_ff;
      blk      = req_phys_addr >> blk_log2_ff;
      set_idx  = SET_W'(blk & ~({ADDR_W{1'b1}} << sets_eff));
      tag      = TAG_W'(blk >> sets_eff);
   end

   // lookup, victim choice and MRU update
   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = CFG_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = CFG_W'(MAX_WAYS);
      end else begin
         ways_eff = ways_ff;
      end

      if (fwd_ff) begin
         row_cur = fwd_row_ff;
      end else if (rd_rowvld_ff) begin
         row_cur = rd_row_ff;
      end else begin
         row_cur = '0;
      end

      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w]  = int'(ways_eff) > w;
         hit_vec[w] = in_use[w] && row_cur.vld[w] && (row_cur.tag[w] == s1_tag_ff);
         inv_vec[w] = in_use[w] && !row_cur.vld[w];
         free_vec[w] = in_use[w] && !row_cur.mru[w];
      end

      hit = |hit_vec;
      if (hit) begin
         way_sel = sacache_pkg::lowest_one(hit_vec);
      end else if (|inv_vec) begin
         way_sel = sacache_pkg::lowest_one(inv_vec);
      end else begin
         way_sel = sacache_pkg::lowest_one(free_vec);
      end
      way_oh = MAX_WAYS'(1) << way_sel;

      row_new = row_cur;
      if (!hit) begin
         row_new.vld[way_sel] = 1'b1;
         row_new.tag[way_sel] = s1_tag_ff;
      end

      // all in-use bits set: clear all but the touched way (all with one way)
      mru_set = row_cur.mru | way_oh;
      mru_clr = (ways_eff == CFG_W'(1)) ? in_use : (in_use & ~way_oh);
      if (&(mru_set | ~in_use)) begin
         row_new.mru = mru_set & ~mru_clr;
      end else begin
         row_new.mru = mru_set;
      end
   end

   // control next values
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept) begin
         s1_vld_in = 1'b1;
      end else if (adv) begin
         s1_vld_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      row_vld_in = row_vld_ff;
      if (adv) begin
         row_vld_in[s1_set_ff] = 1'b1;
      end

      fwd_in = fwd_ff;
      if (accept) begin
         fwd_in = adv && (set_idx == s1_set_ff);
      end

      hit_cnt_in  = hit_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (adv) begin
         if (hit) begin
            hit_cnt_in = hit_cnt_ff + CNT_W'(1);
         end else begin
            miss_cnt_in = miss_cnt_ff + CNT_W'(1);
         end
      end
   end

   // set memory
   always_ff @(posedge clock) begin
      if (adv) begin
         mem[s1_set_ff] <= row_new;
      end
      if (accept) begin
         rd_row_ff <= mem[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_log2_ff  <= sacache_pkg::BLOCK_LOG2_RST;
         sets_log2_ff <= sacache_pkg::SETS_LOG2_RST;
         ways_ff      <= sacache_pkg::WAYS_RST;
         row_vld_ff   <= '0;
         s1_vld_ff    <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
      end else begin
         blk_log2_ff  <= blk_log2_in;
         sets_log2_ff <= sets_log2_in;
         ways_ff      <= ways_in;
         row_vld_ff   <= row_vld_in;
         s1_vld_ff    <= s1_vld_in;
         fwd_ff       <= fwd_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_set_ff    <= set_idx;
         s1_tag_ff    <= tag;
         rd_rowvld_ff <= row_vld_ff[set_idx];
         fwd_row_ff   <= row_new;
      end
      if (adv) begin
         rsp_hit_ff <= hit;
         rsp_way_ff <= way_sel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_way_used   = sacache_pkg::OUT_WAY_W'(rsp_way_ff);
   assign rsp_hit_total  = hit_cnt_ff;
   assign rsp_miss_total = miss_cnt_ff;

endmodule

// ===== src/sacache_chk.sv =====
// ----------------------------------------------------------------------------
// sacache_chk
// Port-level checks for the set-associative cache: output handshake,
// transaction accounting and counter progression.
// ----------------------------------------------------------------------------
module sacache_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_hit,
   input logic [sacache_pkg::OUT_WAY_W-1:0]   rsp_way_used,
   input logic [sacache_pkg::CNT_W-1:0]       rsp_hit_total,
   input logic [sacache_pkg::CNT_W-1:0]       rsp_miss_total
);

   localparam int CNT_W = sacache_pkg::CNT_W;

   logic             req_acc;
   logic             rsp_acc;
   logic [1:0]       pend_ff, pend_in;
   logic [CNT_W-1:0] last_hit_ff, last_hit_in;
   logic [CNT_W-1:0] last_miss_ff, last_miss_in;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in      = pend_ff + 2'(req_acc) - 2'(rsp_acc);
      last_hit_in  = rsp_acc ? rsp_hit_total : last_hit_ff;
      last_miss_in = rsp_acc ? rsp_miss_total : last_miss_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         last_hit_ff  <= '0;
         last_miss_ff <= '0;
      end else begin
         pend_ff      <= pend_in;
         last_hit_ff  <= last_hit_in;
         last_miss_ff <= last_miss_in;
      end
   end

   // stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_way_used)
         && $stable(rsp_hit_total) && $stable(rsp_miss_total))
      else $error("stalled response changed");

   a_rst_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every response belongs to an earlier request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pend_ff != 2'd0)
      else $error("response without request");

   // exactly one counter steps per transaction, matching the hit flag
   a_counters: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> (rsp_hit ?
         (rsp_hit_total == last_hit_ff + CNT_W'(1) && rsp_miss_total == last_miss_ff) :
         (rsp_miss_total == last_miss_ff + CNT_W'(1) && rsp_hit_total == last_hit_ff)))
      else $error("hit or miss count out of step");

endmodule

bind set_assoc_cache_mru_bit_plru sacache_chk u_sacache_chk (.*);

// ===== sim/set_assoc_cache_mru_bit_plru_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_mru_bit_plru_tb
// Self-checking bench for the set-associative cache tag store. Every accepted
// address runs through an in-bench cache model (tags, valid and MRU bits,
// hit and miss counts) and the predicted hit, way and totals are queued.
// Each response transaction is checked against the oldest prediction.
// Directed accesses cover fill order, MRU clearing and victim choice,
// geometry extremes and the case where no victim is found. Random traffic
// then runs through many geometries, with random idle and stall on both
// channels and one long response hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module set_assoc_cache_mru_bit_plru_tb;

   localparam int MAX_SETS      = sacache_pkg::MAX_SETS;
   localparam int MAX_WAYS      = sacache_pkg::MAX_WAYS;
   localparam int ADDR_W        = sacache_pkg::ADDR_W;
   localparam int TAG_W         = sacache_pkg::TAG_W;
   localparam int CNT_W         = sacache_pkg::CNT_W;
   localparam int CFG_W         = sacache_pkg::CFG_W;
   localparam int CSR_IDX_W     = sacache_pkg::CSR_IDX_W;
   localparam int OUT_WAY_W     = sacache_pkg::OUT_WAY_W;
   localparam int SETS_LOG2_MAX = sacache_pkg::SETS_LOG2_MAX;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTS  = 30;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct {
      logic                 hit;
      logic [OUT_WAY_W-1:0] way;
      logic [CNT_W-1:0]     hits;
      logic [CNT_W-1:0]     misses;
   } access_outcome_type;

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [CFG_W-1:0]     csr_wdata     = '0;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [ADDR_W-1:0]    req_phys_addr = '0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic                 rsp_hit;
   logic [OUT_WAY_W-1:0] rsp_way_used;
   logic [CNT_W-1:0]     rsp_hit_total;
   logic [CNT_W-1:0]     rsp_miss_total;

   // cache model state
   logic [TAG_W-1:0] model_tag   [MAX_SETS*MAX_WAYS];
   logic             model_valid [MAX_SETS*MAX_WAYS];
   logic             model_mru   [MAX_SETS*MAX_WAYS];
   logic [CNT_W-1:0] model_hits;
   logic [CNT_W-1:0] model_misses;
   logic [CFG_W-1:0] cfg_block_log2;
   logic [CFG_W-1:0] cfg_sets_log2;
   logic [CFG_W-1:0] cfg_ways;

   access_outcome_type pending_outcomes[$];
   int mismatch_count  = 0;
   int cycle_count     = 0;
   bit req_gaps_on     = 1'b1;
   bit rsp_gaps_on     = 1'b1;
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left       = 0;
   int stall_run_left  = 0;

   set_assoc_cache_mru_bit_plru dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_phys_addr  (req_phys_addr),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_way_used   (rsp_way_used),
      .rsp_hit_total  (rsp_hit_total),
      .rsp_miss_total (rsp_miss_total)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < MAX_SETS*MAX_WAYS; i++) begin
         model_tag[i]   = '0;
         model_valid[i] = 1'b0;
         model_mru[i]   = 1'b0;
      end
      model_hits     = '0;
      model_misses   = '0;
      cfg_block_log2 = sacache_pkg::BLOCK_LOG2_RST;
      cfg_sets_log2  = sacache_pkg::SETS_LOG2_RST;
      cfg_ways       = sacache_pkg::WAYS_RST;
   endfunction

   function automatic access_outcome_type cache_lookup(input logic [ADDR_W-1:0] addr);
      access_outcome_type res;
      int unsigned b, s, ways, blk, set_idx, tag, base, w;
      bit found, all_set;
      b = 32'(cfg_block_log2);
      s = 32'(cfg_sets_log2);
      ways = 32'(cfg_ways);
      while (s > 0 && (1 << s) > MAX_SETS) s--;
      if (ways == 0) ways = 1;
      if (ways > MAX_WAYS) ways = MAX_WAYS;
      blk = addr >> b;
      set_idx = blk & ((1 << s) - 1);
      tag = blk >> s;
      base = set_idx * MAX_WAYS;
      found = 1'b0;
      for (w = 0; w < ways; w++) begin
         if (model_valid[base+w] && model_tag[base+w] == tag) begin
            found = 1'b1;
            break;
         end
      end
      if (found) begin
         model_hits++;
      end else begin
         model_misses++;
         for (w = 0; w < ways; w++) begin
            if (!model_valid[base+w]) break;
         end
         if (w == ways) begin
            for (w = 0; w < ways; w++) begin
               if (!model_mru[base+w]) break;
            end
            if (w == ways) w = 0;
         end
         model_valid[base+w] = 1'b1;
         model_tag[base+w]   = tag;
      end
      // mark touched way, wipe the rest once the set saturates
      model_mru[base+w] = 1'b1;
      all_set = 1'b1;
      for (int k = 0; k < ways; k++) begin
         if (!model_mru[base+k]) all_set = 1'b0;
      end
      if (all_set) begin
         for (int k = 0; k < ways; k++) begin
            if (k != w || ways == 1) model_mru[base+k] = 1'b0;
         end
      end
      res.hit    = found;
      res.way    = w[OUT_WAY_W-1:0];
      res.hits   = model_hits;
      res.misses = model_misses;
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] compose_addr(input int unsigned tag,
         input int unsigned set_idx, input int unsigned b, input int unsigned s);
      logic [ADDR_W-1:0] blk;
      blk = (tag << s) | set_idx;
      return (blk << b) | ($urandom & ((1 << b) - 1));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got,
                  want);
   endtask

   task automatic send_access(input logic [ADDR_W-1:0] addr);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_phys_addr <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outcomes.push_back(cache_lookup(addr));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         sacache_pkg::CSR_BLOCK_BYTES_LOG2: cfg_block_log2 = val;
         sacache_pkg::CSR_SETS_LOG2:        cfg_sets_log2  = val;
         sacache_pkg::CSR_WAYS_IN_USE:      cfg_ways       = val;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] s,
         input logic [CFG_W-1:0] w, input bit poke_unused);
      wait_idle();
      write_csr(sacache_pkg::CSR_BLOCK_BYTES_LOG2, b);
      if (poke_unused) write_csr(CSR_UNUSED_IDX, ~w);
      write_csr(sacache_pkg::CSR_SETS_LOG2, s);
      write_csr(sacache_pkg::CSR_WAYS_IN_USE, w);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // fill order, MRU wipe and eviction at reset geometry
   task automatic test_reset_geometry();
      send_access(32'h0000_0000);
      send_access(32'h0000_0004);
      send_access(32'h0000_0100);
      send_access(32'h0000_0200);
      send_access(32'h0000_0300);
      send_access(32'h0000_0400);
      send_access(32'h0000_0100);
      send_access(32'hFFFF_FFFF);
      send_access(32'hFFFF_FFF0);
   endtask

   // shrink ways so every way in use is valid with its MRU bit set
   task automatic test_no_victim();
      set_geometry(4'd4, 4'd4, 4'd4, 1'b0);
      send_access(32'h0000_0010);
      send_access(32'h0000_0110);
      send_access(32'h0000_0210);
      send_access(32'h0000_0310);
      send_access(32'h0000_0010);
      send_access(32'h0000_0110);
      set_geometry(4'd4, 4'd4, 4'd2, 1'b0);
      send_access(32'h0000_0510);
      send_access(32'h0000_0610);
   endtask

   // single line, oversize fields, zero ways, ignored register index
   task automatic test_geometry_extremes();
      set_geometry(4'd0, 4'd0, 4'd1, 1'b1);
      send_access(32'h0000_0000);
      send_access(32'h0000_0000);
      send_access(32'h0000_0001);
      set_geometry(4'd15, 4'd15, 4'd15, 1'b1);
      send_access(32'hFFFF_FFFF);
      send_access(32'h8000_0000);
      send_access(32'h0000_7FFF);
      set_geometry(4'd11, 4'd9, 4'd0, 1'b0);
      send_access(32'h1234_5678);
      send_access(32'hFFFF_F800);
   endtask

   task automatic test_random_traffic(input int phases, input int per_phase);
      logic [CFG_W-1:0] b, s, w;
      int unsigned s_eff, n_tags, n_sets, b_eff;
      int unsigned tag_pool[10];
      int unsigned set_pool[4];
      for (int p = 0; p < phases; p++) begin
         case (p)
            0: begin b = 4'd4;  s = 4'd4;  w = 4'd4;  end
            1: begin b = 4'd0;  s = 4'd0;  w = 4'd1;  end
            2: begin b = 4'd15; s = 4'd15; w = 4'd15; end
            3: begin b = 4'd10; s = 4'd8;  w = 4'd8;  end
            4: begin b = 4'd11; s = 4'd0;  w = 4'd0;  end
            5: begin b = 4'd2;  s = 4'd1;  w = 4'd2;  end
            default: begin
               b = CFG_W'($urandom_range(0, 15));
               s = CFG_W'($urandom_range(0, 15));
               w = CFG_W'($urandom_range(0, 15));
            end
         endcase
         set_geometry(b, s, w, 1'b0);
         req_gaps_on = (p % 3) != 1;
         rsp_gaps_on = (p % 4) != 2;
         s_eff  = (int'(s) > SETS_LOG2_MAX) ? SETS_LOG2_MAX : 32'(s);
         b_eff  = 32'(b);
         n_tags = $urandom_range(2, 10);
         n_sets = $urandom_range(1, 4);
         foreach (tag_pool[i]) tag_pool[i] = $urandom;
         foreach (set_pool[i]) set_pool[i] = $urandom_range(0, (1 << s_eff) - 1);
         for (int i = 0; i < per_phase; i++) begin
            if ($urandom_range(0, 99) < 85)
               send_access(compose_addr(tag_pool[$urandom_range(0, n_tags-1)],
                                        set_pool[$urandom_range(0, n_sets-1)], b_eff, s_eff));
            else
               send_access($urandom);
         end
      end
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // response side held off while requests keep coming, two busy sets
   task automatic test_backpressure();
      set_geometry(4'd4, 4'd3, 4'd4, 1'b0);
      req_gaps_on = 1'b0;
      holds_requested++;
      for (int i = 0; i < 60; i++)
         send_access(compose_addr($urandom_range(0, 5), $urandom_range(2, 3), 4, 3));
      req_gaps_on = 1'b1;
   endtask

   // response stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_requested) begin
         holds_served <= holds_requested;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (!rsp_gaps_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_run_left > 0) begin
         stall_run_left <= stall_run_left - 1;
      end else begin
         rsp_stall      <= 1'($urandom_range(0, 1));
         stall_run_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : check_results
      access_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with no access pending", rsp_hit_total,
                            rsp_miss_total);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", 32'(rsp_hit), 32'(want.hit));
            if (rsp_way_used !== want.way)
               report_mismatch("way_used", 32'(rsp_way_used), 32'(want.way));
            if (rsp_hit_total !== want.hits)
               report_mismatch("hit_total", rsp_hit_total, want.hits);
            if (rsp_miss_total !== want.misses)
               report_mismatch("miss_total", rsp_miss_total, want.misses);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clear_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_geometry();
      test_no_victim();
      test_geometry_extremes();
      test_random_traffic(12, 80);
      test_backpressure();
      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
